// ----- rtl/core/wmv_pkg.sv -----
// Package with the shared types, sizes and codes of the Wilke mixture viscosity block.
`default_nettype none
package wmv_pkg;

    // Component list capacity.
    localparam int MAX_COMPONENTS = 8;
    localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);
    localparam int IDX_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

    // Field widths of one component and of one result.
    localparam int FRAC_W = 17;
    localparam int MASS_W = 18;
    localparam int VISC_W = 20;

    // Saturation limits of the result fields.
    localparam logic [VISC_W-1:0] VISC_MAX = '1;
    localparam logic [MASS_W-1:0] MASS_MAX = '1;

    // Shared divide / square root unit sizes.
    localparam int DIV_N_W  = 64;
    localparam int DIV_D_W  = 52;
    localparam int SQ_W     = 54;
    localparam int SQ_R_W   = SQ_W / 2;
    localparam int SQ_REM_W = SQ_R_W + 3;
    localparam int STEP_W   = $clog2(DIV_N_W);

    // Datapath widths.
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int PHI_W    = 48;
    localparam int PHI_LO_W = PHI_W / 2;
    localparam int DEN_W    = DIV_D_W;
    localparam int ACC_W    = FRAC_W + VISC_W + 16 + CNT_W;
    localparam int SXM_W    = FRAC_W + MASS_W + CNT_W;
    localparam int SX_W     = FRAC_W + CNT_W;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_OVF = 2'd2
    } t_status;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [FRAC_W-1:0] fraction;
        logic [MASS_W-1:0] mass;
        logic [VISC_W-1:0] viscosity;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic [VISC_W-1:0] mix_viscosity;
        logic [MASS_W-1:0] mix_mass;
        t_status           status;
    } t_out_item;

    typedef struct packed {
        logic [FRAC_W-1:0] frac;
        logic [MASS_W-1:0] mass;
        logic [VISC_W-1:0] visc;
    } t_comp;

    typedef struct packed {
        logic                 start;
        t_alu_op              op;
        logic [DIV_N_W-1:0]   a;
        logic [DIV_D_W-1:0]   b;
    } t_alu_cmd;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] value;
    } t_alu_res;

endpackage
`default_nettype wire

// ----- rtl/core/wmv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wmv_ram #(
    parameter int W = 8,
    parameter int D = 8,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/wmv_arith.sv -----
// Shared iterative unit: restoring divider and integer square root, one bit per cycle.
`default_nettype none
module wmv_arith (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wmv_pkg::t_alu_cmd i_cmd,
    output wmv_pkg::t_alu_res      o_res
);
    import wmv_pkg::*;

    logic                r_busy;
    logic                r_done;
    t_alu_op             r_op;
    logic [STEP_W-1:0]   r_cnt;
    logic [DIV_N_W-1:0]  r_n;
    logic [DIV_D_W:0]    r_rem;
    logic [DIV_D_W-1:0]  r_div;
    logic [SQ_R_W-1:0]   r_root;

    logic [DIV_D_W:0]    div_t;
    logic                div_ge;
    logic [SQ_REM_W-1:0] sq_t;
    logic [SQ_REM_W-1:0] sq_trial;
    logic                sq_ge;
    logic                last_step;

    // One divide step: shift in the next dividend bit and try a subtract.
    assign div_t  = {r_rem[DIV_D_W-1:0], r_n[DIV_N_W-1]};
    assign div_ge = div_t >= {1'b0, r_div};

    // One square root step: bring down two bits and try (4*root + 1).
    assign sq_t     = {r_rem[SQ_REM_W-3:0], r_n[DIV_N_W-1 -: 2]};
    assign sq_trial = SQ_REM_W'({r_root, 2'b01});
    assign sq_ge    = sq_t >= sq_trial;

    assign last_step = (r_op == OP_DIV) ? (r_cnt == STEP_W'(DIV_N_W - 1))
                                        : (r_cnt == STEP_W'(SQ_R_W - 1));

    // Control: busy while iterating, a one-cycle done when the result is ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last_step && !i_cmd.start;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_cmd.op;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_root <= '0;
            r_div  <= i_cmd.b;
            if (i_cmd.op == OP_DIV) begin
                r_n <= i_cmd.a;
            end else begin
                r_n <= {i_cmd.a[SQ_W-1:0], {(DIV_N_W - SQ_W){1'b0}}};
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_op == OP_DIV) begin
                r_rem <= div_ge ? (div_t - {1'b0, r_div}) : div_t;
                r_n   <= {r_n[DIV_N_W-2:0], div_ge};
            end else begin
                r_rem  <= (DIV_D_W + 1)'(sq_ge ? (sq_t - sq_trial) : sq_t);
                r_root <= {r_root[SQ_R_W-2:0], sq_ge};
                r_n    <= {r_n[DIV_N_W-3:0], 2'b00};
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.value = (r_op == OP_DIV) ? r_n : DIV_N_W'(r_root);

endmodule
`default_nettype wire

// ----- rtl/core/wilke_mixture_viscosity.sv -----
// Top level of the Wilke mixture viscosity block.
// Components are loaded one per cycle into an 8-entry store; a request with last set
// closes the list. Wilke's rule is then evaluated for every pair (i, j) on one shared
// bit-serial divide / square root unit and one registered 32x32 multiplier. Each pair
// costs four divides, four square roots, one store read and four multiplies; each
// component adds a divide for its own term when its denominator is nonzero, and the
// mean molar mass adds one more divide. Input is not ready while a list is evaluated.
// Status 2 (too many components) wins over status 1 (zero viscosity or molar mass),
// and both give zero values without any evaluation.
`default_nettype none
module wilke_mixture_viscosity (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire wmv_pkg::t_in_item i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output wmv_pkg::t_out_item     o_data
);
    import wmv_pkg::*;

    typedef enum logic [26:0] {
        S_IDLE  = 27'd1 << 0,
        S_RDI   = 27'd1 << 1,
        S_LATI  = 27'd1 << 2,
        S_RDJ   = 27'd1 << 3,
        S_LATJ  = 27'd1 << 4,
        S_W_DS  = 27'd1 << 5,
        S_W_SS  = 27'd1 << 6,
        S_W_DT  = 27'd1 << 7,
        S_W_ST  = 27'd1 << 8,
        S_W_SF  = 27'd1 << 9,
        S_W_DD  = 27'd1 << 10,
        S_W_SD  = 27'd1 << 11,
        S_MSF   = 27'd1 << 12,
        S_MNN   = 27'd1 << 13,
        S_DPH   = 27'd1 << 14,
        S_W_PHI = 27'd1 << 15,
        S_MPL   = 27'd1 << 16,
        S_MPH   = 27'd1 << 17,
        S_ADJ   = 27'd1 << 18,
        S_ENDI  = 27'd1 << 19,
        S_DAC   = 27'd1 << 20,
        S_W_AC  = 27'd1 << 21,
        S_MXM   = 27'd1 << 22,
        S_AXM   = 27'd1 << 23,
        S_FIN   = 27'd1 << 24,
        S_W_MS  = 27'd1 << 25,
        S_DONE  = 27'd1 << 26
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count;
    logic                r_ovf;
    logic                r_bad;
    logic [CNT_W-1:0]    r_i, r_j;
    logic [FRAC_W-1:0]   r_xi, r_xj;
    logic [MASS_W-1:0]   r_mi, r_mj;
    logic [VISC_W-1:0]   r_vi;
    logic [SQ_R_W-1:0]   r_s, r_f, r_d;
    logic [PHI_W-1:0]    r_phi;
    logic [PROD_W-1:0]   r_prod, r_tmp;
    logic [DEN_W-1:0]    r_den;
    logic [ACC_W-1:0]    r_acc;
    logic [SXM_W-1:0]    r_sxm;
    logic [SX_W-1:0]     r_sx;
    t_out_item           r_res;
    t_out_item           r_out;
    logic                r_ovalid;

    t_alu_cmd            alu_cmd;
    t_alu_res            alu_res;
    t_comp               wr_comp, rd_comp;
    logic                accept, wr_en, in_zero, ovf_now, bad_now;
    logic                mul_en;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [MUL_W-1:0]    num;
    logic [PROD_W-1:0]   x_phi;
    logic [VISC_W-1:0]   visc_sat;
    logic [MASS_W-1:0]   mass_sat;
    logic                out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign wr_en    = accept && (r_count < CNT_W'(MAX_COMPONENTS));
    assign in_zero  = (i_data.mass == '0) || (i_data.viscosity == '0);
    assign ovf_now  = r_ovf || (accept && !wr_en);
    assign bad_now  = r_bad || (wr_en && in_zero);
    assign out_free = !r_ovalid || i_ready;

    assign wr_comp.frac = i_data.fraction;
    assign wr_comp.mass = i_data.mass;
    assign wr_comp.visc = i_data.viscosity;

    // Component store.
    wmv_ram #(.W($bits(t_comp)), .D(MAX_COMPONENTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wr_comp),
        .i_raddr ((r_state == S_RDI) ? r_i[IDX_W-1:0] : r_j[IDX_W-1:0]),
        .o_rdata (rd_comp)
    );

    // Shared divide / square root unit.
    wmv_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (alu_cmd),
        .o_res   (alu_res)
    );

    // Numerator of phi: 1 + s*f in Q16.16.
    assign num   = r_prod[MUL_W+15:16] + MUL_W'(65536);
    // Full x_j * phi from the two partial products.
    assign x_phi = r_tmp + {r_prod[PROD_W-PHI_LO_W-1:0], {PHI_LO_W{1'b0}}};

    assign visc_sat = (|r_acc[ACC_W-1:16+VISC_W]) ? VISC_MAX : r_acc[16 +: VISC_W];
    assign mass_sat = (|alu_res.value[DIV_N_W-1:MASS_W]) ? MASS_MAX
                                                         : alu_res.value[MASS_W-1:0];

    // Sequencer: next state and commands to the shared units.
    always_comb begin
        n_state       = r_state;
        alu_cmd.start = 1'b0;
        alu_cmd.op    = OP_DIV;
        alu_cmd.a     = '0;
        alu_cmd.b     = '0;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_data.last) begin
                    n_state = (ovf_now || bad_now) ? S_DONE : S_RDI;
                end
            end
            S_RDI:  n_state = S_LATI;
            S_LATI: n_state = S_RDJ;
            S_RDJ:  n_state = S_LATJ;
            S_LATJ: begin
                alu_cmd.start = 1'b1;
                alu_cmd.a     = {12'd0, r_vi, 32'd0};
                alu_cmd.b     = DIV_D_W'(rd_comp.visc);
                n_state       = S_W_DS;
            end
            S_W_DS: begin
                if (alu_res.done) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = OP_SQRT;
                    alu_cmd.a     = alu_res.value;
                    n_state       = S_W_SS;
                end
            end
            S_W_SS: begin
                if (alu_res.done) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.a     = {14'd0, r_mj, 32'd0};
                    alu_cmd.b     = DIV_D_W'(r_mi);
                    n_state       = S_W_DT;
                end
            end
            S_W_DT: begin
                if (alu_res.done) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = OP_SQRT;
                    alu_cmd.a     = alu_res.value;
                    n_state       = S_W_ST;
                end
            end
            S_W_ST: begin
                if (alu_res.done) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = OP_SQRT;
                    alu_cmd.a     = {alu_res.value[DIV_N_W-17:0], 16'd0};
                    n_state       = S_W_SF;
                end
            end
            S_W_SF: begin
                if (alu_res.done) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.a     = {14'd0, r_mi, 32'd0};
                    alu_cmd.b     = DIV_D_W'(r_mj);
                    n_state       = S_W_DD;
                end
            end
            S_W_DD: begin
                if (alu_res.done) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = OP_SQRT;
                    alu_cmd.a     = (alu_res.value + 64'h1_0000_0000) << 3;
                    n_state       = S_W_SD;
                end
            end
            S_W_SD: begin
                if (alu_res.done) begin
                    n_state = S_MSF;
                end
            end
            S_MSF: begin
                mul_en  = 1'b1;
                mul_a   = MUL_W'(r_s);
                mul_b   = MUL_W'(r_f);
                n_state = S_MNN;
            end
            S_MNN: begin
                mul_en  = 1'b1;
                mul_a   = num;
                mul_b   = num;
                n_state = S_DPH;
            end
            S_DPH: begin
                alu_cmd.start = 1'b1;
                alu_cmd.a     = r_prod;
                alu_cmd.b     = DIV_D_W'(r_d);
                n_state       = S_W_PHI;
            end
            S_W_PHI: begin
                if (alu_res.done) begin
                    n_state = S_MPL;
                end
            end
            S_MPL: begin
                mul_en  = 1'b1;
                mul_a   = MUL_W'(r_xj);
                mul_b   = MUL_W'(r_phi[PHI_LO_W-1:0]);
                n_state = S_MPH;
            end
            S_MPH: begin
                mul_en  = 1'b1;
                mul_a   = MUL_W'(r_xj);
                mul_b   = MUL_W'(r_phi[PHI_W-1:PHI_LO_W]);
                n_state = S_ADJ;
            end
            S_ADJ: begin
                n_state = (r_j + 1'b1 == r_count) ? S_ENDI : S_RDJ;
            end
            S_ENDI: begin
                if (r_den != '0) begin
                    mul_en  = 1'b1;
                    mul_a   = MUL_W'(r_xi);
                    mul_b   = MUL_W'(r_vi);
                    n_state = S_DAC;
                end else begin
                    n_state = S_MXM;
                end
            end
            S_DAC: begin
                alu_cmd.start = 1'b1;
                alu_cmd.a     = {r_prod[DIV_N_W-17:0], 16'd0};
                alu_cmd.b     = r_den;
                n_state       = S_W_AC;
            end
            S_W_AC: begin
                if (alu_res.done) begin
                    n_state = S_MXM;
                end
            end
            S_MXM: begin
                mul_en  = 1'b1;
                mul_a   = MUL_W'(r_xi);
                mul_b   = MUL_W'(r_mi);
                n_state = S_AXM;
            end
            S_AXM: begin
                n_state = (r_i + 1'b1 == r_count) ? S_FIN : S_RDI;
            end
            S_FIN: begin
                if (r_sx != '0) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.a     = DIV_N_W'(r_sxm);
                    alu_cmd.b     = DIV_D_W'(r_sx);
                    n_state       = S_W_MS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_W_MS: begin
                if (alu_res.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_bad    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (accept) begin
                if (i_data.last && (ovf_now || bad_now)) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_bad   <= 1'b0;
                end else begin
                    if (wr_en) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_ovf <= ovf_now;
                    r_bad <= bad_now;
                end
            end else if (r_state == S_FIN) begin
                r_count <= '0;
                r_bad   <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        case (r_state)
            S_IDLE: begin
                r_i   <= '0;
                r_acc <= '0;
                r_sxm <= '0;
                r_sx  <= '0;
                if (ovf_now) begin
                    r_res <= '{mix_viscosity: '0, mix_mass: '0, status: ST_OVF};
                end else begin
                    r_res <= '{mix_viscosity: '0, mix_mass: '0, status: ST_BAD};
                end
            end
            S_LATI: begin
                r_xi  <= rd_comp.frac;
                r_mi  <= rd_comp.mass;
                r_vi  <= rd_comp.visc;
                r_j   <= '0;
                r_den <= '0;
            end
            S_LATJ: begin
                r_xj <= rd_comp.frac;
                r_mj <= rd_comp.mass;
            end
            S_W_SS: if (alu_res.done) r_s <= alu_res.value[SQ_R_W-1:0];
            S_W_SF: if (alu_res.done) r_f <= alu_res.value[SQ_R_W-1:0];
            S_W_SD: if (alu_res.done) r_d <= alu_res.value[SQ_R_W-1:0];
            S_W_PHI: if (alu_res.done) r_phi <= alu_res.value[PHI_W-1:0];
            S_MPH: r_tmp <= r_prod;
            S_ADJ: begin
                r_den <= r_den + DEN_W'(x_phi >> 16);
                r_j   <= r_j + 1'b1;
            end
            S_W_AC: if (alu_res.done) r_acc <= r_acc + ACC_W'(alu_res.value);
            S_MXM: r_sx <= r_sx + SX_W'(r_xi);
            S_AXM: begin
                r_sxm <= r_sxm + SXM_W'(r_prod);
                r_i   <= r_i + 1'b1;
            end
            S_FIN: begin
                r_res <= '{mix_viscosity: visc_sat, mix_mass: '0, status: ST_OK};
            end
            S_W_MS: if (alu_res.done) r_res.mix_mass <= mass_sat;
            S_DONE: if (out_free) r_out <= r_res;
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

// ----- rtl/core/wmv_checker.sv -----
// Port-level checker for the Wilke mixture viscosity block, with its bind statement.
`default_nettype none
module wmv_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_ready,
    input wire wmv_pkg::t_in_item i_data,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire wmv_pkg::t_out_item o_data
);
    import wmv_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // An error status never carries values.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status != ST_OK) |->
            (o_data.mix_viscosity == '0) && (o_data.mix_mass == '0))
        else $error("error result with nonzero values");

    // Closing a list makes the block busy in the next cycle.
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.last |=> !o_ready)
        else $error("ready right after a closing request");

endmodule

bind wilke_mixture_viscosity wmv_checker u_wmv_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
`default_nettype wire

// ----- tb/wmv_result_checker.sv -----
// Checker that predicts Wilke mixture results from accepted requests and compares them.
`default_nettype none
module wmv_result_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_ready,
    input  wire wmv_pkg::t_in_item  i_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire wmv_pkg::t_out_item i_out_data,
    output int                      o_fail_count,
    output int                      o_pending
);
    import wmv_pkg::*;

    // Component list as the block should hold it, kept at 64 bits for the math.
    logic [63:0] comp_frac [MAX_COMPONENTS];
    logic [63:0] comp_mass [MAX_COMPONENTS];
    logic [63:0] comp_visc [MAX_COMPONENTS];
    int          comp_count;
    bit          list_overflow;

    t_out_item   expected_results [$];
    int          mismatch_count;

    // Floor of the square root of a 64-bit value.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Interaction factor between components i and j in Q16.16.
    function automatic logic [63:0] interaction(input int i, input int j);
        logic [63:0] s, t, f, num, d;
        s   = floor_sqrt((comp_visc[i] << 32) / comp_visc[j]);
        t   = floor_sqrt((comp_mass[j] << 32) / comp_mass[i]);
        f   = floor_sqrt(t << 16);
        num = 64'd65536 + ((s * f) >> 16);
        d   = floor_sqrt(64'd8 * ((64'd1 << 32) + (comp_mass[i] << 32) / comp_mass[j]));
        return (num * num) / d;
    endfunction

    // Mixture result of the list held now.
    function automatic t_out_item mixture_of_list();
        t_out_item   res;
        logic [63:0] acc, sum_xm, sum_x, den, visc_v, mass_v;
        bit          bad;
        res = '0;
        bad = 0;
        for (int i = 0; i < comp_count; i++)
            if (comp_mass[i] == 0 || comp_visc[i] == 0) bad = 1;
        if (list_overflow) begin
            res.status = ST_OVF;
        end else if (bad) begin
            res.status = ST_BAD;
        end else begin
            acc = 0;
            sum_xm = 0;
            sum_x = 0;
            for (int i = 0; i < comp_count; i++) begin
                den = 0;
                for (int j = 0; j < comp_count; j++)
                    den = den + ((comp_frac[j] * interaction(i, j)) >> 16);
                if (den > 0)
                    acc = acc + ((comp_frac[i] * comp_visc[i]) << 16) / den;
                sum_xm = sum_xm + comp_frac[i] * comp_mass[i];
                sum_x  = sum_x + comp_frac[i];
            end
            visc_v = acc >> 16;
            if (visc_v > 64'(VISC_MAX)) visc_v = 64'(VISC_MAX);
            mass_v = (sum_x > 0) ? sum_xm / sum_x : 0;
            if (mass_v > 64'(MASS_MAX)) mass_v = 64'(MASS_MAX);
            res.mix_viscosity = visc_v[VISC_W-1:0];
            res.mix_mass      = mass_v[MASS_W-1:0];
            res.status        = ST_OK;
        end
        return res;
    endfunction

    assign o_fail_count = mismatch_count;
    assign o_pending    = expected_results.size();

    // Track accepted requests and compare every accepted result.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            comp_count    = 0;
            list_overflow = 0;
            mismatch_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("Unexpected result: visc %0d mass %0d status %0d",
                                 i_out_data.mix_viscosity, i_out_data.mix_mass,
                                 i_out_data.status);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.mix_viscosity !== i_out_data.mix_viscosity ||
                        want.mix_mass !== i_out_data.mix_mass ||
                        want.status !== i_out_data.status) begin
                        if (mismatch_count < 10)
                            $display("Mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.mix_viscosity, want.mix_mass, want.status,
                                     i_out_data.mix_viscosity, i_out_data.mix_mass,
                                     i_out_data.status);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (i_valid && i_ready) begin
                // Blocking updates so the closing request sees its own component.
                if (comp_count < MAX_COMPONENTS) begin
                    comp_frac[comp_count] = 64'(i_data.fraction);
                    comp_mass[comp_count] = 64'(i_data.mass);
                    comp_visc[comp_count] = 64'(i_data.viscosity);
                    comp_count = comp_count + 1;
                end else begin
                    list_overflow = 1;
                end
                if (i_data.last) begin
                    expected_results.push_back(mixture_of_list());
                    comp_count = 0;
                    list_overflow = 0;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- tb/wilke_mixture_viscosity_tb.sv -----
// Testbench top: drives component lists into the block and gives the verdict.
`default_nettype none
module wilke_mixture_viscosity_tb;
    import wmv_pkg::*;

    localparam int STALL_LIMIT = 250000;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_valid = 0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 0;
    t_out_item o_data;

    int  fail_count;
    int  pending;
    bit  idling_on = 1;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    int  items_sent = 0;

    wilke_mixture_viscosity i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    wmv_result_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready(o_ready), .i_data(i_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // Result side stalls in random bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 0;
            stall_left <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 3) == 0) begin
            i_ready <= 0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            i_ready <= 1;
        end
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one request, sometimes with a random gap in front of it.
    task automatic send_component(input logic [16:0] frac, input logic [17:0] mass,
                                  input logic [19:0] visc, input logic last);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_valid <= 1;
        i_data  <= '{fraction: frac, mass: mass, viscosity: visc, last: last};
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Field value biased toward extremes; zero only when allowed.
    function automatic logic [19:0] pick_value(input int unsigned top, input bit zero_ok);
        case ($urandom_range(0, 9))
            0: return 20'(top);
            1: return 20'($urandom_range(1, 16));
            2: return zero_ok ? 20'd0 : 20'(top);
            default: return 20'($urandom_range(1, top));
        endcase
    endfunction

    function automatic logic [16:0] pick_fraction();
        case ($urandom_range(0, 9))
            0: return 17'd65536;
            1: return 17'd0;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // One random list; mostly short well-formed lists, some bad or overlong.
    task automatic send_random_list();
        int  n;
        int  kind;
        bit  zero_ok;
        kind = $urandom_range(0, 99);
        if (kind < 55)      n = $urandom_range(1, 2);
        else if (kind < 80) n = $urandom_range(3, 4);
        else if (kind < 84) n = $urandom_range(5, 8);
        else                n = $urandom_range(9, 12);
        zero_ok = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n; k++)
            send_component(pick_fraction(), 18'(pick_value(262143, zero_ok)),
                           pick_value(1048575, zero_ok), k == n - 1);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: extremes of each field.
        send_component(17'd65536, 18'd262143, 20'd1048575, 1);
        send_component(17'd0, 18'd1, 20'd1, 1);
        send_component(17'd65536, 18'd1, 20'd1048575, 0);
        send_component(17'd65536, 18'd262143, 20'd1, 1);
        // Zero viscosity, then zero molar mass.
        send_component(17'd30000, 18'd1000, 20'd0, 1);
        send_component(17'd30000, 18'd0, 20'd1000, 0);
        send_component(17'd100, 18'd5, 20'd5, 1);
        // A full list.
        for (int k = 0; k < MAX_COMPONENTS; k++)
            send_component(17'($urandom_range(0, 65536)), 18'($urandom_range(1, 262143)),
                           20'($urandom_range(1, 1048575)), k == MAX_COMPONENTS - 1);
        // One too many, with a zero viscosity inside: overflow wins.
        for (int k = 0; k <= MAX_COMPONENTS; k++)
            send_component(17'd20000, 18'd40000, (k == 3) ? 20'd0 : 20'd18000,
                           k == MAX_COMPONENTS);

        // Random lists; the final stretch runs without idling.
        while (items_sent < 950) begin
            if (items_sent > 810) idling_on = 0;
            send_random_list();
        end
        i_valid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/wmv_pkg.sv
rtl/core/wmv_ram.sv
rtl/core/wmv_arith.sv
rtl/core/wilke_mixture_viscosity.sv
rtl/core/wmv_checker.sv
tb/wmv_result_checker.sv
tb/wilke_mixture_viscosity_tb.sv
